### rtl/core/i2w_pkg.sv
// ---------------------------------------------------------------------------
// i2w_pkg: shared types and constants for the integer-to-word token block
// Token codes, sequencer states, emission slots and the power-of-ten table
// used by the compare-subtract digit extractor.
// ---------------------------------------------------------------------------
package i2w_pkg;

  localparam int unsigned ValueW  = 31;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned GroupW  = 3 * DigitW;
  localparam int unsigned NumGrp  = 4;
  localparam int unsigned DigitsW = NumGrp * GroupW;
  localparam int unsigned PowW    = 34;

  localparam logic [CodeW-1:0] CodeZero     = 5'd0;
  localparam logic [CodeW-1:0] CodeTensBase = 5'd18;
  localparam logic [CodeW-1:0] CodeHundred  = 5'd28;
  localparam logic [CodeW-1:0] CodeThousand = 5'd29;
  localparam logic [CodeW-1:0] CodeMillion  = 5'd30;
  localparam logic [CodeW-1:0] CodeBillion  = 5'd31;

  localparam logic [3:0] TopDigit = 4'd9;
  localparam logic [1:0] TopBit   = 2'd3;
  localparam logic [1:0] TopGroup = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StExtract,
    StEmit,
    StZero
  } state_e;

  typedef enum logic [2:0] {
    SlotHundDigit,
    SlotHundWord,
    SlotTens,
    SlotOnes,
    SlotScale
  } slot_e;

  // 10^k shifted left by b: the trial subtrahend for digit k, weight 2^b
  function automatic logic [PowW-1:0] pow_step(input logic [3:0] k, input logic [1:0] b);
    logic [PowW-1:0] base;
    case (k)
      4'd0:    base = 34'd1;
      4'd1:    base = 34'd10;
      4'd2:    base = 34'd100;
      4'd3:    base = 34'd1000;
      4'd4:    base = 34'd10000;
      4'd5:    base = 34'd100000;
      4'd6:    base = 34'd1000000;
      4'd7:    base = 34'd10000000;
      4'd8:    base = 34'd100000000;
      4'd9:    base = 34'd1000000000;
      default: base = '0;
    endcase
    return base << b;
  endfunction

  function automatic logic [CodeW-1:0] scale_code(input logic [1:0] grp);
    logic [CodeW-1:0] code;
    case (grp)
      2'd3:    code = CodeBillion;
      2'd2:    code = CodeMillion;
      2'd1:    code = CodeThousand;
      default: code = CodeZero;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/integer_to_word_tokens_top.sv
// ---------------------------------------------------------------------------
// integer_to_word_tokens_top: spell a 31-bit integer as English word tokens
// A shared compare-subtract unit splits the value into ten decimal digits,
// then a slot sequencer walks the four three-digit groups and emits tokens.
// ---------------------------------------------------------------------------
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid_i, in_ready_o, value_i      | in
//   result  | out_valid_o, out_ready_i,            | out
//           | word_code_o, last_word_o             |
//
// Digit extraction runs one compare-subtract per cycle, with four
// binary-weighted trials for each of ten decimal digits. Emission then handles
// one slot per cycle, five slots for each of four groups, while the result
// side does not stall. A zero value skips extraction and loads its single
// zero token once the result register is free, then the block is idle again.
// Reset clears the sequencer and the result valid flag; no clearing pass.
// in_ready_o is high only while idle; a token waiting in the result
// register does not block the next transfer on the input side.
module integer_to_word_tokens_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [i2w_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [i2w_pkg::CodeW-1:0]  word_code_o,
  output logic                       last_word_o
);
  import i2w_pkg::*;

  state_e               state_q, state_d;
  slot_e                slot_q, slot_d;
  logic [ValueW-1:0]    rem_q, rem_d;
  logic [DigitW-1:0]    dig_q, dig_d;
  logic [DigitsW-1:0]   digits_q, digits_d;
  logic [3:0]           dig_idx_q, dig_idx_d;
  logic [1:0]           bit_idx_q, bit_idx_d;
  logic [1:0]           grp_idx_q, grp_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [CodeW-1:0]     code_q, code_d;
  logic                 last_q, last_d;

  logic                 in_xfer;
  logic [PowW-1:0]      trial;
  logic                 ge;
  logic [DigitW-1:0]    dig_new;
  logic                 extract_done;
  logic [GroupW-1:0]    grp;
  logic [DigitW-1:0]    hund, tens, ones;
  logic                 g_last, teen, lower_zero;
  logic                 tok;
  logic [CodeW-1:0]     tok_code;
  logic                 tok_last;
  logic                 out_free;
  logic                 advance;
  logic                 emit_done;

  assign in_ready_o  = (state_q == StIdle);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign word_code_o = code_q;
  assign last_word_o = last_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // shared compare-subtract unit
  assign trial   = pow_step(dig_idx_q, bit_idx_q);
  assign ge      = ({{(PowW-ValueW){1'b0}}, rem_q} >= trial);
  assign dig_new = dig_q | (ge ? (DigitW'(1) << bit_idx_q) : '0);
  assign extract_done = (dig_idx_q == '0) && (bit_idx_q == '0);

  // current group sits in the top twelve bits of the digit shift line
  assign grp        = digits_q[DigitsW-1 -: GroupW];
  assign hund       = grp[3*DigitW-1 -: DigitW];
  assign tens       = grp[2*DigitW-1 -: DigitW];
  assign ones       = grp[DigitW-1:0];
  assign g_last     = (grp_idx_q == '0);
  assign teen       = (tens < 4'd2);
  assign lower_zero = (digits_q[DigitsW-GroupW-1:0] == '0);

  always_comb begin
    tok      = 1'b0;
    tok_code = CodeZero;
    tok_last = 1'b0;
    case (slot_q)
      SlotHundDigit: begin
        tok      = (hund != '0);
        tok_code = {1'b0, hund};
      end
      SlotHundWord: begin
        tok      = (hund != '0);
        tok_code = CodeHundred;
        tok_last = g_last && (tens == '0) && (ones == '0);
      end
      SlotTens: begin
        tok = (tens != '0) || (ones != '0);
        if (teen) begin
          tok_code = {1'b0, ones} + (tens[0] ? 5'd10 : 5'd0);
          tok_last = g_last;
        end else begin
          tok_code = CodeTensBase + {1'b0, tens};
          tok_last = g_last && (ones == '0);
        end
      end
      SlotOnes: begin
        tok      = !teen && (ones != '0);
        tok_code = {1'b0, ones};
        tok_last = g_last;
      end
      SlotScale: begin
        tok      = !g_last && (grp != '0);
        tok_code = scale_code(grp_idx_q);
        tok_last = lower_zero;
      end
      default: begin
        tok = 1'b0;
      end
    endcase
  end

  assign advance   = !tok || out_free;
  assign emit_done = (slot_q == SlotScale) && g_last;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = (value_i == '0) ? StZero : StExtract;
        end
      end
      StExtract: begin
        if (extract_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (advance && emit_done) begin
          state_d = StIdle;
        end
      end
      StZero: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    rem_d       = rem_q;
    dig_d       = dig_q;
    digits_d    = digits_q;
    dig_idx_d   = dig_idx_q;
    bit_idx_d   = bit_idx_q;
    grp_idx_d   = grp_idx_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    code_d      = code_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        rem_d     = value_i;
        dig_d     = '0;
        digits_d  = '0;
        dig_idx_d = TopDigit;
        bit_idx_d = TopBit;
        grp_idx_d = TopGroup;
        slot_d    = SlotHundDigit;
      end
      StExtract: begin
        if (ge) begin
          rem_d = rem_q - trial[ValueW-1:0];
        end
        if (bit_idx_q == '0) begin
          digits_d  = {digits_q[DigitsW-DigitW-1:0], dig_new};
          dig_d     = '0;
          bit_idx_d = TopBit;
          dig_idx_d = dig_idx_q - 4'd1;
        end else begin
          dig_d     = dig_new;
          bit_idx_d = bit_idx_q - 2'd1;
        end
      end
      StEmit: begin
        if (advance) begin
          if (tok) begin
            out_valid_d = 1'b1;
            code_d      = tok_code;
            last_d      = tok_last;
          end
          if (slot_q == SlotScale) begin
            slot_d    = SlotHundDigit;
            grp_idx_d = grp_idx_q - 2'd1;
            digits_d  = {digits_q[DigitsW-GroupW-1:0], {GroupW{1'b0}}};
          end else begin
            slot_d = slot_e'(slot_q + 3'd1);
          end
        end
      end
      StZero: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = CodeZero;
          last_d      = 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= SlotHundDigit;
      dig_idx_q   <= '0;
      bit_idx_q   <= '0;
      grp_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      dig_idx_q   <= dig_idx_d;
      bit_idx_q   <= bit_idx_d;
      grp_idx_q   <= grp_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    dig_q    <= dig_d;
    digits_q <= digits_d;
    code_q   <= code_d;
    last_q   <= last_d;
  end

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for integer_to_word_tokens_top
// Drives 31-bit values over the input handshake, predicts the English word
// token stream of each value and checks every result transfer in order.
// Covers directed edge values, a long receiver hold-off and random traffic.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2w_pkg::*;

  typedef struct {
    logic [CodeW-1:0] code;
    logic             last;
  } word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CodeW-1:0]  word_code_o;
  logic              last_word_o;

  word_t pending_words[$];

  int unsigned numbers_sent;
  int unsigned words_checked;
  int unsigned zero_values;
  int unsigned longest_spelling;
  int unsigned mismatches;

  bit sender_gaps;
  bit receiver_stalls;
  int unsigned hold_off_len;

  integer_to_word_tokens_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .word_code_o(word_code_o),
    .last_word_o(last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Spell one value and queue its tokens, most significant group first.
  function automatic void spell_number(input logic [ValueW-1:0] v);
    logic [CodeW-1:0] toks[$];
    int unsigned n;
    int unsigned divisor;
    int unsigned grp;
    int unsigned hund;
    int unsigned rest;
    word_t w;
    n = v;
    if (n == 0) begin
      toks = {toks, CodeZero};
      zero_values++;
    end else begin
      for (int g = 3; g >= 0; g--) begin
        divisor = 1;
        repeat (g) divisor = divisor * 1000;
        grp = (n / divisor) % 1000;
        if (grp != 0) begin
          hund = grp / 100;
          rest = grp % 100;
          if (hund != 0) begin
            toks = {toks, CodeW'(hund)};
            toks = {toks, CodeHundred};
          end
          if (rest != 0 && rest < 20) begin
            toks = {toks, CodeW'(rest)};
          end else if (rest != 0) begin
            toks = {toks, CodeW'(CodeTensBase + rest / 10)};
            if (rest % 10 != 0) toks = {toks, CodeW'(rest % 10)};
          end
          case (g)
            3: toks = {toks, CodeBillion};
            2: toks = {toks, CodeMillion};
            1: toks = {toks, CodeThousand};
            default: ;
          endcase
        end
      end
    end
    if (toks.size() > longest_spelling) longest_spelling = toks.size();
    foreach (toks[i]) begin
      w.code = toks[i];
      w.last = (i == toks.size() - 1);
      pending_words = {pending_words, w};
    end
  endfunction

  // Random value: full range, a single group, sparse groups, or near a boundary.
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned kind;
    longint unsigned v;
    kind = $urandom_range(0, 3);
    case (kind)
      0: v = $urandom & 32'h7FFF_FFFF;
      1: v = $urandom_range(0, 999);
      2: begin
        v = $urandom_range(0, 1) * 64'd1000000000;
        if ($urandom_range(0, 2) != 0) v += $urandom_range(0, 999) * 64'd1000000;
        if ($urandom_range(0, 2) != 0) v += $urandom_range(0, 999) * 64'd1000;
        if ($urandom_range(0, 2) != 0) v += $urandom_range(0, 999);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 64'd1000 + $urandom_range(0, 20) - 10;
          1: v = 64'd1000000 + $urandom_range(0, 20) - 10;
          2: v = 64'd1000000000 + $urandom_range(0, 20) - 10;
          default: v = 64'd2147483647 - $urandom_range(0, 20);
        endcase
      end
    endcase
    return v[ValueW-1:0];
  endfunction

  // Offer one value and hold it until the transfer happens.
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    spell_number(v);
    numbers_sent++;
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, or one long hold-off when requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_len - 1) @(negedge clk_i);
        hold_off_len = 0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word transfer code=%0d last=%0b", $time,
                 word_code_o, last_word_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (word_code_o !== want.code) begin
          $display("%0t: word_code expected %0d actual %0d", $time, want.code, word_code_o);
          mismatches++;
        end
        if (last_word_o !== want.last) begin
          $display("%0t: last_word expected %0b actual %0b", $time, want.last, last_word_o);
          mismatches++;
        end
      end
    end
  end

  task automatic test_edge_values();
    logic [ValueW-1:0] vals[$];
    vals = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001,
             1000000, 1000000000, 2000000000, 2147483647, 1234567890, 999999999,
             100100100, 31'h2AAA_AAAA, 31'h5555_5555};
    foreach (vals[i]) send_value(vals[i]);
    drain_words();
  endtask

  // Hold the result side off while values keep coming, so the input stalls.
  task automatic test_result_hold_off();
    sender_gaps  = 1'b0;
    hold_off_len = 400;
    repeat (6) send_value(pick_value());
    drain_words();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_values();
    for (int i = 0; i < 100; i++) begin
      if (i == 75) begin
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
      end
      send_value(pick_value());
    end
    drain_words();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    value_i         = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_off_len    = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_edge_values();
    test_result_hold_off();
    test_random_values();

    $display("Spelled %0d numbers (%0d zero), checked %0d word tokens, longest run %0d.",
             numbers_sent, zero_values, words_checked, longest_spelling);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[integer_to_word_tokens_top] OK");
    end else begin
      $display("[integer_to_word_tokens_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d word tokens outstanding", pending_words.size());
    $display("[integer_to_word_tokens_top] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/i2w_pkg.sv
rtl/core/integer_to_word_tokens_top.sv
sim/tb.sv
